/* src/ldr_pkg.sv */
// Shared types, constants and helpers for the longest distinct run tracker.
`timescale 1ns / 1ps

package ldr_pkg;

    // Bits per symbol; the alphabet and the window ring both have 2^SYM_W entries.
    localparam int SYM_W   = 8;
    localparam int ALPHA   = 1 << SYM_W;
    localparam int RING_W  = 8;
    localparam int OUT_W   = 8;
    localparam int OUT_MAX = (1 << OUT_W) - 1;

    typedef logic [SYM_W-1:0] t_sym;

    // The symbol value that ends a string.
    localparam t_sym SYM_END = '0;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    // One access to the window ring: a write port and a read port.
    typedef struct packed {
        logic              we;
        t_sym              waddr;
        logic [RING_W-1:0] wdata;
        t_sym              raddr;
    } t_ring_req;

    // Result handed from the controller to the output register.
    typedef struct packed {
        logic             load;
        logic [OUT_W-1:0] length;
    } t_result;

    // Clamp a window length to the width of the result field.
    function automatic logic [OUT_W-1:0] f_sat_len(input t_sym len);
        if (int'(len) > OUT_MAX) begin
            f_sat_len = OUT_W'(OUT_MAX);
        end else begin
            f_sat_len = OUT_W'(len);
        end
    endfunction

endpackage

/* src/longest_distinct_run_tracker.sv */
// Top level of the longest distinct run tracker: controller, window ring and result register.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake               Payload
//  input    in         i_in_valid/o_in_stall   i_symbol (8 bits)
//  output   out        o_out_valid/i_out_stall o_longest_length (8 bits)
//
//  A new symbol is appended as it is taken. A repeated symbol is followed by pops of symbols from
//  the front of the window while the input stalls, since each pop needs one read of the window ring;
//  the last pop also appends the new symbol. A zero symbol loads the
//  result register. Reset is synchronous and active low; the presence bitmap clears at once.
//  The result register frees the input side, but a new beat is held off while a result
//  waits under stall, so no result is lost.

module longest_distinct_run_tracker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_symbol,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_longest_length
);
    import ldr_pkg::*;

    t_result           res;
    t_ring_req         ring_req;
    logic [RING_W-1:0] ring_rdata;
    logic              out_busy;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_len;

    // A waiting result that the sink still stalls keeps the block from taking a beat.
    assign out_busy = r_out_valid && i_out_stall;

    ldr_window_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_symbol     (i_symbol),
        .i_out_busy   (out_busy),
        .o_res        (res),
        .o_ring_req   (ring_req),
        .i_ring_rdata (ring_rdata)
    );

    ldr_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_req   (ring_req),
        .o_rdata (ring_rdata)
    );

    // Result register. It loads only when empty or being drained in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_len <= res.length;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_longest_length = r_out_len;

`ifndef ASSERT_OFF
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_symbol[SYM_W-1:0] == SYM_END) |=> o_out_valid)
        else $error("string end beat produced no result");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !res.load) |=> !o_out_valid)
        else $error("result repeated after it was taken");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("beat accepted while a result waits under stall");
`endif

endmodule

/* src/ldr_ring_ram.sv */
// Window ring memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ldr_ring_ram (
    input  logic                      i_clk,
    input  ldr_pkg::t_ring_req        i_req,
    output logic [ldr_pkg::RING_W-1:0] o_rdata
);
    import ldr_pkg::*;

    logic [RING_W-1:0] r_mem [ALPHA];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* src/ldr_window_ctrl.sv */
// Window controller: presence bitmap, ring pointers, best length and the pop sequencer.
`timescale 1ns / 1ps

module ldr_window_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_symbol,
    input  logic                       i_out_busy,
    output ldr_pkg::t_result           o_res,
    output ldr_pkg::t_ring_req         o_ring_req,
    input  logic [ldr_pkg::RING_W-1:0] i_ring_rdata
);
    import ldr_pkg::*;

    t_state           r_state, n_state;
    t_sym             r_head, n_head;
    t_sym             r_len, n_len;
    t_sym             r_best, n_best;
    t_sym             r_sym, n_sym;
    logic [ALPHA-1:0] r_present, n_present;

    logic accept;
    t_sym sym;
    t_sym tail;
    t_sym len_inc;
    t_sym popped;

    always_comb begin
        sym        = i_symbol[SYM_W-1:0];
        o_in_stall = (r_state != ST_IDLE) || i_out_busy;
        accept     = i_in_valid && !o_in_stall;
        tail       = r_head + r_len;
        len_inc    = r_len + t_sym'(1);
        popped     = i_ring_rdata[SYM_W-1:0];

        n_state   = r_state;
        n_head    = r_head;
        n_len     = r_len;
        n_best    = r_best;
        n_sym     = r_sym;
        n_present = r_present;

        o_ring_req.we    = 1'b0;
        o_ring_req.waddr = tail;
        o_ring_req.wdata = RING_W'(r_sym);
        o_ring_req.raddr = r_head;

        o_res.load   = 1'b0;
        o_res.length = f_sat_len(r_best);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (sym == SYM_END) begin
                        o_res.load = 1'b1;
                        n_present  = '0;
                        n_head     = '0;
                        n_len      = '0;
                        n_best     = '0;
                    end else if (r_present[sym]) begin
                        // The front entry is read at this edge; popping starts next cycle.
                        n_sym   = sym;
                        n_state = ST_POP;
                    end else if (r_len < t_sym'(ALPHA - 1)) begin
                        o_ring_req.we    = 1'b1;
                        o_ring_req.wdata = RING_W'(sym);
                        n_present[sym]   = 1'b1;
                        n_len            = len_inc;
                        if (len_inc > r_best) begin
                            n_best = len_inc;
                        end
                    end
                end
            end
            ST_POP: begin
                // Drop the front symbol and fetch the one behind it.
                n_present[popped] = 1'b0;
                n_head            = r_head + t_sym'(1);
                n_len             = r_len - t_sym'(1);
                o_ring_req.raddr  = r_head + t_sym'(1);
                if (popped == r_sym || r_len == t_sym'(1)) begin
                    // The earlier copy is gone; append the new one at the unchanged tail.
                    o_ring_req.we    = 1'b1;
                    n_present[r_sym] = 1'b1;
                    n_len            = r_len;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_len     <= '0;
            r_best    <= '0;
            r_present <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_len     <= n_len;
            r_best    <= n_best;
            r_present <= n_present;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
    end

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_POP |-> r_len != '0)
        else $error("pop sequencer running on an empty window");

    a_map_matches_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_present) == int'(r_len))
        else $error("presence bitmap count differs from window length");

    a_best_covers_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best >= r_len)
        else $error("best length fell below the current window length");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && sym == SYM_END) |=> (r_len == '0 && r_best == '0 && r_head == '0))
        else $error("string end did not clear the window");
`endif

endmodule
